// ===== rtl/core/cdq_pkg.sv =====
// Shared types and constants for the circular deque core.
// Used by cdq_ctrl and circular_deque; depends on nothing else.
`timescale 1ns / 1ps

package cdq_pkg;

    // Fixed field widths of the streaming payload and the capacity register.
    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int OCC_W  = 11;
    localparam int CAP_W  = 11;

    // Packed widths of the stream ports, padded to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 8;

    // Word reported for the front or rear of an empty deque.
    localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK       = 3'd4
    } op_t;

    // Status of one operation, handed from the control logic to the result stage.
    typedef struct packed {
        logic accepted;
        logic is_empty;
        logic is_full;
    } op_status_t;

endpackage

// ===== rtl/core/cdq_ram.sv =====
// Ring store of the circular deque: one write port and two read ports.
// Read data is registered; no package dependencies.
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int WORD_W = 32
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WORD_W-1:0] rd_data_a,
    output logic [WORD_W-1:0] rd_data_b
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Reads return the contents before a write in the same cycle.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== rtl/core/cdq_ctrl.sv =====
// Pointer, count and capacity state of the circular deque, with the
// next-state logic for one operation. Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_ctrl import cdq_pkg::*; #(
    parameter int MAX_DEPTH = 1024,
    parameter int ADDR_W    = 10,
    parameter int CNT_W     = 11
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    input  logic              advance,
    input  logic [OP_W-1:0]   op,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [ADDR_W-1:0] rd_front_addr,
    output logic [ADDR_W-1:0] rd_rear_addr,
    output logic [CNT_W-1:0]  count_after,
    output op_status_t        status
);

    localparam int IW = ADDR_W + 1;

    logic [ADDR_W-1:0] front_reg, front_next;
    logic [ADDR_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [31:0]       cap_wide;
    logic              full_now;
    logic              empty_now;
    logic              ok;

    function automatic logic [ADDR_W-1:0] step_up(input logic [ADDR_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cap);
        logic [IW-1:0] n;
        n = IW'(idx) + IW'(1);
        return (n >= IW'(cap)) ? '0 : ADDR_W'(n);
    endfunction

    function automatic logic [ADDR_W-1:0] step_down(input logic [ADDR_W-1:0] idx,
                                                    input logic [CNT_W-1:0] cap);
        return (idx == '0) ? ADDR_W'(cap - CNT_W'(1)) : idx - ADDR_W'(1);
    endfunction

    // A capacity of zero is taken as one, and anything beyond the store saturates.
    always_comb begin
        cap_wide = 32'(cfg_wr_data);
        if (cap_wide == 32'd0) begin
            cap_wide = 32'd1;
        end else if (cap_wide > 32'(MAX_DEPTH)) begin
            cap_wide = 32'(MAX_DEPTH);
        end
        cap_next = CNT_W'(cap_wide);
    end

    always_comb begin
        full_now   = (count_reg >= cap_reg);
        empty_now  = (count_reg == '0);
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = back_reg;
        ok         = 1'b0;
        unique case (op)
            OP_PUSH_FRONT: begin
                if (!full_now) begin
                    front_next = step_down(front_reg, cap_reg);
                    wr_en      = 1'b1;
                    wr_addr    = front_next;
                    count_next = count_reg + CNT_W'(1);
                    ok         = 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (!full_now) begin
                    wr_en      = 1'b1;
                    wr_addr    = back_reg;
                    back_next  = step_up(back_reg, cap_reg);
                    count_next = count_reg + CNT_W'(1);
                    ok         = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (!empty_now) begin
                    front_next = step_up(front_reg, cap_reg);
                    count_next = count_reg - CNT_W'(1);
                    ok         = 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (!empty_now) begin
                    back_next  = step_down(back_reg, cap_reg);
                    count_next = count_reg - CNT_W'(1);
                    ok         = 1'b1;
                end
            end
            OP_PEEK: begin
                ok = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        rd_front_addr   = front_next;
        rd_rear_addr    = step_down(back_next, cap_reg);
        count_after     = count_next;
        status.accepted = ok;
        status.is_empty = (count_next == '0);
        status.is_full  = (count_next >= cap_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CNT_W'(MAX_DEPTH);
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            cap_reg   <= cap_next;
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end else if (advance) begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    a_count_within_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_reg)
        else $error("element count exceeds capacity");

    a_pointers_within_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (IW'(front_reg) < IW'(cap_reg)) && (IW'(back_reg) < IW'(cap_reg)))
        else $error("ring pointer beyond capacity");

    a_cfg_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (count_reg == '0) && (front_reg == '0) && (back_reg == '0))
        else $error("capacity write did not empty the deque");

endmodule

// ===== rtl/core/circular_deque.sv =====
// Top level of the circular deque: stream ports, result register and the
// instances of cdq_ctrl and cdq_ram. Depends on cdq_pkg.
`timescale 1ns / 1ps
//
// Usage:
// Each input transaction on the s_axis channel carries one operation in
// s_axis_tuser (push front, push back, pop front, pop back, peek) and a
// signed word in s_axis_tdata that a push stores. Every input transaction
// gives exactly one output transaction on m_axis, which reports whether the
// operation succeeded and the deque after it: front and rear words (all ones
// when empty), the occupancy and the empty and full flags.
// The result of an accepted transaction is registered and offered on m_axis
// from the next cycle. Throughput is one transaction per cycle while m_axis
// does not stall; the ring store's registered read ports set that figure,
// since both ends are read in the same cycle as the pointers move, while a
// push of the same cycle is forwarded around the store.
// s_axis_tready is high whenever the result register is empty or its
// transaction is being taken, so a stall on m_axis holds the result and
// stops the input until m_axis_tready returns.
// After reset the deque is empty and the capacity is MAX_DEPTH. The store
// itself is not cleared: only slots written by a push are ever shown, so the
// block is ready straight out of reset. Writing the capacity
// register (cfg_wr_en) empties the deque; do it only while the block is idle.

module circular_deque import cdq_pkg::*; #(
    parameter int MAX_DEPTH = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Capacity register: 1 to MAX_DEPTH slots; 0 reads as 1.
    input  logic                 cfg_wr_en,
    input  logic [CAP_W-1:0]     cfg_wr_data,
    // Input channel.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [31:0] value
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [2:0] operation, [7:3] zero
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    // Result channel.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [31:0] front_value, [63:32] rear_value, [74:64] occupancy,
    // [75] is_empty, [76] is_full, [79:77] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [0] accepted, [7:1] zero
    output logic [M_TUSER_W-1:0] m_axis_tuser
);

    localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_DEPTH + 1);

    logic              advance;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_front_addr;
    logic [ADDR_W-1:0] rd_rear_addr;
    logic [CNT_W-1:0]  count_after;
    op_status_t        status;
    logic [DATA_W-1:0] rd_front_data;
    logic [DATA_W-1:0] rd_rear_data;
    logic [DATA_W-1:0] front_word;
    logic [DATA_W-1:0] rear_word;

    // Result register. The store's read data registers sit beside it, and the
    // forward flags pick the pushed word where a read hit the slot just written.
    logic              out_valid_reg, out_valid_next;
    op_status_t        status_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic              fwd_front_reg;
    logic              fwd_rear_reg;
    logic [DATA_W-1:0] push_word_reg;

    assign s_axis_tready  = !out_valid_reg || m_axis_tready;
    assign advance        = s_axis_tvalid && s_axis_tready;
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    cdq_ctrl #(
        .MAX_DEPTH (MAX_DEPTH),
        .ADDR_W    (ADDR_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .advance       (advance),
        .op            (s_axis_tuser[OP_W-1:0]),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .rd_front_addr (rd_front_addr),
        .rd_rear_addr  (rd_rear_addr),
        .count_after   (count_after),
        .status        (status)
    );

    // The store is written only for an accepted transaction whose push succeeded.
    cdq_ram #(
        .DEPTH  (MAX_DEPTH),
        .ADDR_W (ADDR_W),
        .WORD_W (DATA_W)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (advance && wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (s_axis_tdata[DATA_W-1:0]),
        .rd_en     (advance),
        .rd_addr_a (rd_front_addr),
        .rd_addr_b (rd_rear_addr),
        .rd_data_a (rd_front_data),
        .rd_data_b (rd_rear_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset; they load with each accepted transaction.
    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg    <= status;
            occ_reg       <= OCC_W'(count_after);
            fwd_front_reg <= wr_en && (wr_addr == rd_front_addr);
            fwd_rear_reg  <= wr_en && (wr_addr == rd_rear_addr);
            push_word_reg <= s_axis_tdata[DATA_W-1:0];
        end
    end

    always_comb begin
        if (status_reg.is_empty) begin
            front_word = EMPTY_WORD;
            rear_word  = EMPTY_WORD;
        end else begin
            front_word = fwd_front_reg ? push_word_reg : rd_front_data;
            rear_word  = fwd_rear_reg ? push_word_reg : rd_rear_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, status_reg.is_full, status_reg.is_empty, occ_reg,
                            rear_word, front_word};
    assign m_axis_tuser  = {7'b0000000, status_reg.accepted};

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_axis_tvalid)
        else $error("accepted transaction produced no result");

    a_empty_shows_all_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && status_reg.is_empty) |->
            (front_word == EMPTY_WORD) && (rear_word == EMPTY_WORD) && (occ_reg == '0))
        else $error("empty result carries stale words or count");

    a_full_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && status_reg.is_full) |-> !status_reg.is_empty)
        else $error("result flagged both full and empty");

endmodule
